// File: sv/hdrtm_pkg.sv
package hdrtm_pkg;

  localparam int LUT_INDEX_BITS   = 12;
  localparam int LINEAR_FRAC_BITS = 16;

  localparam int LIN_W      = 16 + LINEAR_FRAC_BITS;
  localparam int LUT_SIZE   = (2 ** LUT_INDEX_BITS) + 1;
  localparam int LUT_ADDR_W = LUT_INDEX_BITS + 1;

  // half decode: mantissa (11b) times gain (16b), then shift by exponent
  localparam int PROD_W    = 27;
  localparam int DEC_SHIFT = 38 - LINEAR_FRAC_BITS;
  localparam int SHIFT_W   = PROD_W + 30;

  localparam int RATIO_W  = 18;
  localparam int QUO_BITS = 18;
  localparam int NUM_W    = LIN_W + 18;

  localparam logic [LIN_W:0]     LIN_ONE       = (LIN_W + 1)'(1) << LINEAR_FRAC_BITS;
  localparam logic [LIN_W-1:0]   LIN_MAX       = '1;
  localparam logic [LIN_W-1:0]   LUM_THRESHOLD = LIN_W'((2 ** LINEAR_FRAC_BITS) / 1000000);
  localparam logic [RATIO_W-1:0] RATIO_MAX     = RATIO_W'(2 ** 17);
  localparam logic [SHIFT_W-1:0] DEC_ROUND     = SHIFT_W'(1) << (DEC_SHIFT - 1);
  localparam logic [16:0]        HALF_Q16      = 17'h08000;

  localparam logic [15:0] LUM_COEF_R = 16'd13933;
  localparam logic [15:0] LUM_COEF_G = 16'd46871;
  localparam logic [15:0] LUM_COEF_B = 16'd4732;

  // pipeline stage numbers
  localparam int ST_DEC     = 0;
  localparam int ST_LIN     = 1;
  localparam int ST_LUMP    = 2;
  localparam int ST_LUM     = 3;
  localparam int ST_IW      = 4;
  localparam int ST_NUM     = 5;
  localparam int ST_SPLIT   = 6;
  localparam int ST_RATIO   = ST_SPLIT + QUO_BITS + 1;
  localparam int ST_SCALE   = ST_RATIO + 1;
  localparam int ST_INDEX   = ST_SCALE + 1;
  localparam int ST_OUT     = ST_INDEX + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  typedef enum logic [0:0] {
    REG_EXPOSURE_GAIN     = 1'b0,
    REG_INV_WHITE_SQUARED = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] red_half;
    logic [15:0] green_half;
    logic [15:0] blue_half;
  } pixel_t;

  typedef struct packed {
    logic [7:0] blue_byte;
    logic [7:0] green_byte;
    logic [7:0] red_byte;
  } result_t;

  // sRGB encode table, built at elaboration
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] LOW_DIV     = 64'd10 << LUT_INDEX_BITS;
  localparam logic [63:0] HIGH_DIV    = 64'd1000 << 30;
  localparam logic [63:0] SRGB_OFFSET = 64'd14025 << 30;
  localparam logic [63:0] SRGB_ROUND  = 64'd500 << 30;

  typedef logic [LUT_SIZE-1:0][7:0] srgb_lut_t;

  function automatic logic [7:0] srgb_entry(input int unsigned i);
    logic [63:0] x, x2, x4, target, lo, hi, mid, y2, y4, y8, p12, t, code;
    x = 64'(i);
    code = '0;
    if (x * 64'd10000000 <= (64'd31308 << LUT_INDEX_BITS)) begin
      code = (64'd32946 * x + (64'd5 << LUT_INDEX_BITS)) / LOW_DIV;
    end else begin
      x = x << (30 - LUT_INDEX_BITS);
      x2 = (x * x) >> 30;
      x4 = (x2 * x2) >> 30;
      target = (x4 * x) >> 30;
      lo = '0;
      hi = Q30_ONE;
      for (int k = 0; k < 32; k++) begin
        if (lo < hi) begin
          mid = lo + ((hi - lo + 64'd1) >> 1);
          y2 = (mid * mid) >> 30;
          y4 = (y2 * y2) >> 30;
          y8 = (y4 * y4) >> 30;
          p12 = (y8 * y4) >> 30;
          if (p12 <= target) begin
            lo = mid;
          end else begin
            hi = mid - 64'd1;
          end
        end
      end
      t = 64'd269025 * lo;
      t = (t > SRGB_OFFSET) ? t - SRGB_OFFSET : 64'd0;
      code = (t + SRGB_ROUND) / HIGH_DIV;
    end
    return (code > 64'd255) ? 8'd255 : code[7:0];
  endfunction

  function automatic srgb_lut_t build_srgb_lut();
    srgb_lut_t lut;
    for (int i = 0; i < LUT_SIZE; i++) begin
      lut[i] = srgb_entry(i);
    end
    return lut;
  endfunction

  localparam srgb_lut_t SRGB_LUT = build_srgb_lut();

endpackage

// File: sv/hdr_half_to_srgb8_tonemap_top.sv
// HDR half-float to sRGB 8-bit tone mapper. One pixel (R, G, B binary16) per beat in, one
// B/G/R byte triple per beat out, one pixel per clock sustained while not stalled. Decode,
// exposure, luminance and Reinhard numerator take 7 stages, the ratio divider retires one
// quotient bit per stage over 18 stages, then scaling, quantizing and the registered sRGB
// table read. Stalls propagate stage by stage, so bubbles collapse and the input keeps
// flowing while the output is held, until empty stages fill. Registers are written through
// the cfg port (ready is always high) and must only change while the pipeline is empty.
module hdr_half_to_srgb8_tonemap_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  hdrtm_pkg::pixel_t   pixel,
  output logic                result_valid,
  input  logic                result_stall,
  output hdrtm_pkg::result_t  result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  hdrtm_pkg::cfg_reg_t cfg_index,
  input  logic [15:0]         cfg_data
);

  typedef struct packed {
    logic [hdrtm_pkg::PROD_W-1:0] prod;
    logic [4:0]                   amt;
    logic                         sat;
    logic                         zero;
  } dec_t;

  typedef struct packed {
    logic [hdrtm_pkg::LIN_W-1:0] r;
    logic [hdrtm_pkg::LIN_W-1:0] g;
    logic [hdrtm_pkg::LIN_W-1:0] b;
  } lin_rgb_t;

  typedef struct packed {
    logic [hdrtm_pkg::LIN_W:0]      rem;
    logic [hdrtm_pkg::QUO_BITS-1:0] low;
    logic [hdrtm_pkg::QUO_BITS-1:0] quo;
    logic [hdrtm_pkg::LIN_W:0]      den;
    logic                           ovf;
    logic                           nz;
  } div_t;

  localparam int LUMP_W  = hdrtm_pkg::LIN_W + 16;
  localparam int SCALE_W = hdrtm_pkg::LIN_W + hdrtm_pkg::RATIO_W;
  localparam int SREM_W  = SCALE_W + 1 - 16;
  localparam int IDXT_W  = hdrtm_pkg::LINEAR_FRAC_BITS + hdrtm_pkg::LUT_INDEX_BITS + 2;

  function automatic dec_t decode_half(input logic [15:0] h, input logic [15:0] gain);
    dec_t d;
    logic [10:0] mag;
    mag = (h[14:10] == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
    d.prod = hdrtm_pkg::PROD_W'(mag) * hdrtm_pkg::PROD_W'(gain);
    d.amt  = (h[14:10] == 5'd0) ? 5'd0 : h[14:10] - 5'd1;
    d.sat  = (h[14:10] == 5'h1f) && ((h[9:0] != 10'd0) || !h[15]);
    d.zero = h[15] && !d.sat;
    return d;
  endfunction

  function automatic logic [hdrtm_pkg::LIN_W-1:0] expose(input dec_t d);
    logic [hdrtm_pkg::SHIFT_W-1:0] w;
    logic [hdrtm_pkg::SHIFT_W-1:0] v;
    logic [hdrtm_pkg::LIN_W-1:0]   lin;
    w = (hdrtm_pkg::SHIFT_W'(d.prod) << d.amt) + hdrtm_pkg::DEC_ROUND;
    v = w >> hdrtm_pkg::DEC_SHIFT;
    if (d.sat || (v[hdrtm_pkg::SHIFT_W-1:hdrtm_pkg::LIN_W] != '0)) begin
      lin = hdrtm_pkg::LIN_MAX;
    end else begin
      lin = v[hdrtm_pkg::LIN_W-1:0];
    end
    return d.zero ? '0 : lin;
  endfunction

  function automatic div_t div_step(input div_t d);
    div_t n;
    logic [hdrtm_pkg::LIN_W+1:0] t;
    logic [hdrtm_pkg::LIN_W+1:0] diff;
    logic                        ge;
    n = d;
    t = {d.rem, d.low[hdrtm_pkg::QUO_BITS-1]};
    diff = t - {1'b0, d.den};
    ge = t >= {1'b0, d.den};
    n.rem = ge ? diff[hdrtm_pkg::LIN_W:0] : t[hdrtm_pkg::LIN_W:0];
    n.low = {d.low[hdrtm_pkg::QUO_BITS-2:0], 1'b0};
    n.quo = {d.quo[hdrtm_pkg::QUO_BITS-2:0], ge};
    return n;
  endfunction

  function automatic logic [hdrtm_pkg::LUT_ADDR_W-1:0] to_index(
    input logic [SCALE_W-1:0] p
  );
    logic [SCALE_W:0]                         pr;
    logic [SREM_W-1:0]                        s;
    logic [hdrtm_pkg::LINEAR_FRAC_BITS:0]     sc;
    logic [IDXT_W-1:0]                        t;
    logic [hdrtm_pkg::LUT_ADDR_W-1:0]         idx;
    pr = {1'b0, p} + (SCALE_W + 1)'(hdrtm_pkg::HALF_Q16);
    s  = pr[SCALE_W:16];
    if (s > SREM_W'(hdrtm_pkg::LIN_ONE)) begin
      sc = hdrtm_pkg::LIN_ONE[hdrtm_pkg::LINEAR_FRAC_BITS:0];
    end else begin
      sc = s[hdrtm_pkg::LINEAR_FRAC_BITS:0];
    end
    t = (IDXT_W'(sc) << hdrtm_pkg::LUT_INDEX_BITS)
      + (IDXT_W'(1) << (hdrtm_pkg::LINEAR_FRAC_BITS - 1));
    idx = t[hdrtm_pkg::LINEAR_FRAC_BITS +: hdrtm_pkg::LUT_ADDR_W];
    if (idx > hdrtm_pkg::LUT_ADDR_W'(hdrtm_pkg::LUT_SIZE - 1)) begin
      idx = hdrtm_pkg::LUT_ADDR_W'(hdrtm_pkg::LUT_SIZE - 1);
    end
    return idx;
  endfunction

  logic [15:0] exposure_gain;
  logic [15:0] inv_white_squared;

  logic [hdrtm_pkg::NUM_STAGES-1:0] vld;
  logic [hdrtm_pkg::NUM_STAGES-1:0] en;

  dec_t                          dec_r, dec_g, dec_b;
  lin_rgb_t                      chan [hdrtm_pkg::ST_LIN:hdrtm_pkg::ST_RATIO];
  logic [LUMP_W-1:0]             lump_r, lump_g, lump_b;
  logic [hdrtm_pkg::LIN_W-1:0]   lum;
  logic [LUMP_W-1:0]             iw_prod;
  logic [hdrtm_pkg::LIN_W:0]     den_iw, den_num;
  logic                          nz_iw, nz_num;
  logic [hdrtm_pkg::LIN_W:0]     num;
  div_t                          dv [0:hdrtm_pkg::QUO_BITS];
  logic [hdrtm_pkg::RATIO_W-1:0] ratio;
  logic [SCALE_W-1:0]            scl_r, scl_g, scl_b;
  logic [hdrtm_pkg::LUT_ADDR_W-1:0] idx_r, idx_g, idx_b;

  logic [LUMP_W+1:0]             lum_sum;

  // backpressure: a stage loads when it is empty or its successor loads
  assign en[hdrtm_pkg::ST_OUT] = !vld[hdrtm_pkg::ST_OUT] || !result_stall;
  for (genvar k = 0; k < hdrtm_pkg::ST_OUT; k++) begin : g_en
    assign en[k] = !vld[k] || en[k+1];
  end

  assign pixel_stall  = !en[hdrtm_pkg::ST_DEC];
  assign result_valid = vld[hdrtm_pkg::ST_OUT];
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < hdrtm_pkg::NUM_STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= (k == 0) ? pixel_valid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_gain     <= 16'd6554;
      inv_white_squared <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        hdrtm_pkg::REG_EXPOSURE_GAIN:     exposure_gain     <= cfg_data;
        hdrtm_pkg::REG_INV_WHITE_SQUARED: inv_white_squared <= cfg_data;
      endcase
    end
  end

  // decode and exposure multiply
  always_ff @(posedge clk) begin
    if (en[hdrtm_pkg::ST_DEC]) begin
      dec_r <= decode_half(pixel.red_half, exposure_gain);
      dec_g <= decode_half(pixel.green_half, exposure_gain);
      dec_b <= decode_half(pixel.blue_half, exposure_gain);
    end
  end

  // align, round, saturate to linear fixed point
  always_ff @(posedge clk) begin
    if (en[hdrtm_pkg::ST_LIN]) begin
      chan[hdrtm_pkg::ST_LIN].r <= expose(dec_r);
      chan[hdrtm_pkg::ST_LIN].g <= expose(dec_g);
      chan[hdrtm_pkg::ST_LIN].b <= expose(dec_b);
    end
  end

  for (genvar k = hdrtm_pkg::ST_LIN + 1; k <= hdrtm_pkg::ST_RATIO; k++) begin : g_chan
    always_ff @(posedge clk) begin
      if (en[k]) begin
        chan[k] <= chan[k-1];
      end
    end
  end

  // luminance
  always_ff @(posedge clk) begin
    if (en[hdrtm_pkg::ST_LUMP]) begin
      lump_r <= LUMP_W'(chan[hdrtm_pkg::ST_LIN].r) * LUMP_W'(hdrtm_pkg::LUM_COEF_R);
      lump_g <= LUMP_W'(chan[hdrtm_pkg::ST_LIN].g) * LUMP_W'(hdrtm_pkg::LUM_COEF_G);
      lump_b <= LUMP_W'(chan[hdrtm_pkg::ST_LIN].b) * LUMP_W'(hdrtm_pkg::LUM_COEF_B);
    end
  end

  assign lum_sum = (LUMP_W + 2)'(lump_r) + (LUMP_W + 2)'(lump_g) + (LUMP_W + 2)'(lump_b)
                 + (LUMP_W + 2)'(hdrtm_pkg::HALF_Q16);

  always_ff @(posedge clk) begin
    if (en[hdrtm_pkg::ST_LUM]) begin
      lum <= lum_sum[16 +: hdrtm_pkg::LIN_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en[hdrtm_pkg::ST_IW]) begin
      iw_prod <= LUMP_W'(lum) * LUMP_W'(inv_white_squared);
      den_iw  <= (hdrtm_pkg::LIN_W + 1)'(lum) + hdrtm_pkg::LIN_ONE;
      nz_iw   <= lum > hdrtm_pkg::LUM_THRESHOLD;
    end
  end

  logic [LUMP_W:0] iw_round;
  assign iw_round = (LUMP_W + 1)'(iw_prod) + (LUMP_W + 1)'(hdrtm_pkg::HALF_Q16);

  always_ff @(posedge clk) begin
    if (en[hdrtm_pkg::ST_NUM]) begin
      num     <= (hdrtm_pkg::LIN_W + 1)'(iw_round[16 +: hdrtm_pkg::LIN_W])
               + hdrtm_pkg::LIN_ONE;
      den_num <= den_iw;
      nz_num  <= nz_iw;
    end
  end

  // dividend = num * 2^16 + den / 2; high part feeds the bit-serial divider
  logic [hdrtm_pkg::NUM_W-1:0] dividend;
  logic [hdrtm_pkg::LIN_W-1:0] div_hi;
  assign dividend = (hdrtm_pkg::NUM_W'(num) << 16) + hdrtm_pkg::NUM_W'(den_num >> 1);
  assign div_hi   = dividend[hdrtm_pkg::NUM_W-1:hdrtm_pkg::QUO_BITS];

  always_ff @(posedge clk) begin
    if (en[hdrtm_pkg::ST_SPLIT]) begin
      dv[0].rem <= {1'b0, div_hi};
      dv[0].low <= dividend[hdrtm_pkg::QUO_BITS-1:0];
      dv[0].quo <= '0;
      dv[0].den <= den_num;
      dv[0].ovf <= {1'b0, div_hi} >= den_num;
      dv[0].nz  <= nz_num;
    end
  end

  for (genvar j = 1; j <= hdrtm_pkg::QUO_BITS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (en[hdrtm_pkg::ST_SPLIT + j]) begin
        dv[j] <= div_step(dv[j-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[hdrtm_pkg::ST_RATIO]) begin
      if (!dv[hdrtm_pkg::QUO_BITS].nz) begin
        ratio <= '0;
      end else if (dv[hdrtm_pkg::QUO_BITS].ovf
                   || (dv[hdrtm_pkg::QUO_BITS].quo > hdrtm_pkg::RATIO_MAX)) begin
        ratio <= hdrtm_pkg::RATIO_MAX;
      end else begin
        ratio <= dv[hdrtm_pkg::QUO_BITS].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[hdrtm_pkg::ST_SCALE]) begin
      scl_r <= SCALE_W'(chan[hdrtm_pkg::ST_RATIO].r) * SCALE_W'(ratio);
      scl_g <= SCALE_W'(chan[hdrtm_pkg::ST_RATIO].g) * SCALE_W'(ratio);
      scl_b <= SCALE_W'(chan[hdrtm_pkg::ST_RATIO].b) * SCALE_W'(ratio);
    end
  end

  always_ff @(posedge clk) begin
    if (en[hdrtm_pkg::ST_INDEX]) begin
      idx_r <= to_index(scl_r);
      idx_g <= to_index(scl_g);
      idx_b <= to_index(scl_b);
    end
  end

  // sRGB table read, registered into the output beat
  always_ff @(posedge clk) begin
    if (en[hdrtm_pkg::ST_OUT]) begin
      result.blue_byte  <= hdrtm_pkg::SRGB_LUT[idx_b];
      result.green_byte <= hdrtm_pkg::SRGB_LUT[idx_g];
      result.red_byte   <= hdrtm_pkg::SRGB_LUT[idx_r];
    end
  end

endmodule
